### rtl/core/rppc_pkg.sv
// Shared types and constants for the ray plane pair clipping block.
`default_nettype none
package rppc_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int ADDR_W    = 5;
  localparam int DIV_STEPS = 31;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 66;
  localparam int NUM_W     = 67;

  localparam logic [1:0] SURF_SIDE   = 2'd0;
  localparam logic [1:0] SURF_BOTTOM = 2'd1;
  localparam logic [1:0] SURF_TOP    = 2'd2;

  localparam logic [2:0] REG_BOTTOM_A = 3'd0;
  localparam logic [2:0] REG_BOTTOM_B = 3'd1;
  localparam logic [2:0] REG_BOTTOM_C = 3'd2;
  localparam logic [2:0] REG_BOTTOM_D = 3'd3;
  localparam logic [2:0] REG_TOP_A    = 3'd4;
  localparam logic [2:0] REG_TOP_B    = 3'd5;
  localparam logic [2:0] REG_TOP_C    = 3'd6;
  localparam logic [2:0] REG_TOP_D    = 3'd7;

  typedef struct packed {
    logic dc_zero;
    logic dc_neg;
    logic dw_neg;
  } plane_flags_t;

endpackage
`default_nettype wire

### rtl/core/rppc_plane.sv
// Plane dot products and pipelined crossing distance divider for one plane.
`default_nettype none
module rppc_plane #(
  parameter int FRAC_BITS = 16
) (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  wire logic signed [31:0]   plane_a_i,
  input  wire logic signed [31:0]   plane_b_i,
  input  wire logic signed [31:0]   plane_c_i,
  input  wire logic signed [31:0]   plane_d_i,
  input  wire logic signed [31:0]   origin_x_i,
  input  wire logic signed [31:0]   origin_y_i,
  input  wire logic signed [31:0]   origin_z_i,
  input  wire logic signed [31:0]   dir_x_i,
  input  wire logic signed [31:0]   dir_y_i,
  input  wire logic signed [31:0]   dir_z_i,
  output logic signed [31:0]        t_o,
  output rppc_pkg::plane_flags_t    flags_o
);

  localparam int DW = 67 - FRAC_BITS;
  localparam int RW = DW + 1;
  localparam int NS = rppc_pkg::DIV_STEPS;

  logic signed [rppc_pkg::PROD_W-1:0] pc_q [3];
  logic signed [rppc_pkg::PROD_W-1:0] pw_q [3];
  logic signed [31:0]                 d1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q[0] <= 64'(plane_a_i) * 64'(dir_x_i);
      pc_q[1] <= 64'(plane_b_i) * 64'(dir_y_i);
      pc_q[2] <= 64'(plane_c_i) * 64'(dir_z_i);
      pw_q[0] <= 64'(plane_a_i) * 64'(origin_x_i);
      pw_q[1] <= 64'(plane_b_i) * 64'(origin_y_i);
      pw_q[2] <= 64'(plane_c_i) * 64'(origin_z_i);
      d1_q    <= plane_d_i;
    end
  end

  logic signed [rppc_pkg::SUM_W-1:0] sc, sw, sc_sh, sw_sh;
  logic signed [DW-1:0] dc_d, dw_d, dc_q, dw_q;

  always_comb begin
    sc    = 66'(pc_q[0]) + 66'(pc_q[1]) + 66'(pc_q[2]);
    sw    = 66'(pw_q[0]) + 66'(pw_q[1]) + 66'(pw_q[2]);
    sc_sh = sc >>> FRAC_BITS;
    sw_sh = sw >>> FRAC_BITS;
    dc_d  = DW'(sc_sh);
    dw_d  = DW'(sw_sh) + DW'(d1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dc_q <= dc_d;
      dw_q <= dw_d;
    end
  end

  rppc_pkg::plane_flags_t flg_d;
  logic [DW-1:0]          n_mag, d_mag;
  logic [rppc_pkg::NUM_W-1:0] num;
  logic [RW-1:0]          rem0;
  logic                   neg_d, ovf_d;

  always_comb begin
    flg_d.dc_zero = (dc_q == '0);
    flg_d.dc_neg  = dc_q[DW-1];
    flg_d.dw_neg  = dw_q[DW-1];
    neg_d = (flg_d.dw_neg == flg_d.dc_neg);
    n_mag = flg_d.dw_neg ? DW'(-dw_q) : DW'(dw_q);
    d_mag = flg_d.dc_neg ? DW'(-dc_q) : DW'(dc_q);
    num   = {n_mag, {FRAC_BITS{1'b0}}};
    rem0  = RW'(num[rppc_pkg::NUM_W-1:NS]);
    ovf_d = (rem0 >= RW'(d_mag));
  end

  logic [RW-1:0]          rem_q [NS+1];
  logic [DW-1:0]          dd_q  [NS+1];
  logic [NS-1:0]          nlo_q [NS+1];
  logic [NS-1:0]          quo_q [NS+1];
  logic                   neg_q [NS+1];
  logic                   ovf_q [NS+1];
  rppc_pkg::plane_flags_t flg_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      dd_q[0]  <= d_mag;
      nlo_q[0] <= num[NS-1:0];
      quo_q[0] <= '0;
      neg_q[0] <= neg_d;
      ovf_q[0] <= ovf_d;
      flg_q[0] <= flg_d;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [RW-1:0] r2;
    logic          ge;

    always_comb begin
      r2 = {rem_q[k-1][RW-2:0], nlo_q[k-1][NS-1]};
      ge = (r2 >= RW'(dd_q[k-1]));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (r2 - RW'(dd_q[k-1])) : r2;
        dd_q[k]  <= dd_q[k-1];
        nlo_q[k] <= {nlo_q[k-1][NS-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][NS-2:0], ge};
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  logic signed [31:0] t_d, t_q;
  rppc_pkg::plane_flags_t flg_out_q;

  always_comb begin
    if (ovf_q[NS]) begin
      t_d = neg_q[NS] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg_q[NS]) begin
      t_d = -$signed({1'b0, quo_q[NS]});
    end else begin
      t_d = $signed({1'b0, quo_q[NS]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q       <= t_d;
      flg_out_q <= flg_q[NS];
    end
  end

  assign t_o     = t_q;
  assign flags_o = flg_out_q;

endmodule
`default_nettype wire

### rtl/core/rppc_clip.sv
// Two stage interval clipping against the bottom plane and then the top plane.
`default_nettype none
module rppc_clip (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire logic signed [31:0]      enter_i,
  input  wire logic signed [31:0]      exit_i,
  input  wire logic signed [31:0]      t_bot_i,
  input  wire rppc_pkg::plane_flags_t  flags_bot_i,
  input  wire logic signed [31:0]      t_top_i,
  input  wire rppc_pkg::plane_flags_t  flags_top_i,
  output logic                         hit_o,
  output logic signed [31:0]           new_enter_o,
  output logic signed [31:0]           new_exit_o,
  output logic [1:0]                   enter_surface_o,
  output logic [1:0]                   exit_surface_o
);

  logic signed [31:0]     en_d, ex_d, en_q, ex_q, ttop_q;
  logic [1:0]             sin_d, sout_d, sin_q, sout_q;
  logic                   hit_d, hit_q;
  rppc_pkg::plane_flags_t ftop_q;
  logic                   ins_b;

  always_comb begin
    en_d   = enter_i;
    ex_d   = exit_i;
    sin_d  = rppc_pkg::SURF_SIDE;
    sout_d = rppc_pkg::SURF_SIDE;
    hit_d  = 1'b1;
    ins_b  = (t_bot_i > enter_i) && (t_bot_i < exit_i);
    if (flags_bot_i.dc_zero) begin
      hit_d = flags_bot_i.dw_neg;
    end else if (!flags_bot_i.dc_neg) begin
      if (ins_b) begin
        ex_d   = t_bot_i;
        sout_d = rppc_pkg::SURF_BOTTOM;
      end
      if (t_bot_i < enter_i) begin
        hit_d = 1'b0;
      end
    end else begin
      if (ins_b) begin
        en_d  = t_bot_i;
        sin_d = rppc_pkg::SURF_BOTTOM;
      end
      if (t_bot_i > exit_i) begin
        hit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      en_q   <= en_d;
      ex_q   <= ex_d;
      sin_q  <= sin_d;
      sout_q <= sout_d;
      hit_q  <= hit_d;
      ttop_q <= t_top_i;
      ftop_q <= flags_top_i;
    end
  end

  logic signed [31:0] en2, ex2;
  logic [1:0]         sin2, sout2;
  logic               hit2, ins_t;

  always_comb begin
    en2   = en_q;
    ex2   = ex_q;
    sin2  = sin_q;
    sout2 = sout_q;
    hit2  = hit_q;
    ins_t = (ttop_q > en_q) && (ttop_q < ex_q);
    if (ftop_q.dc_zero) begin
      if (!ftop_q.dw_neg) begin
        hit2 = 1'b0;
      end
    end else if (!ftop_q.dc_neg) begin
      if (ins_t) begin
        ex2   = ttop_q;
        sout2 = rppc_pkg::SURF_TOP;
      end
      if (ttop_q < en_q) begin
        hit2 = 1'b0;
      end
    end else begin
      if (ins_t) begin
        en2  = ttop_q;
        sin2 = rppc_pkg::SURF_TOP;
      end
      if (ttop_q > ex_q) begin
        hit2 = 1'b0;
      end
    end
    if (!(en2 < ex2)) begin
      hit2 = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o           <= hit2;
      new_enter_o     <= hit2 ? en2 : '0;
      new_exit_o      <= hit2 ? ex2 : '0;
      enter_surface_o <= hit2 ? sin2 : rppc_pkg::SURF_SIDE;
      exit_surface_o  <= hit2 ? sout2 : rppc_pkg::SURF_SIDE;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ray_plane_pair_clip.sv
// Top level: ray interval clipping against a bottom and a top plane.
// The path from input transfer to result has one multiply stage, one sum stage,
// one setup stage, 31 divider steps, one quotient stage and two clipping stages.
// Throughput is one ray per cycle; the whole pipeline holds while a result is stalled.
// Reset clears all valid bits and sets every plane register to zero.
`default_nettype none
module ray_plane_pair_clip #(
  parameter int FRAC_BITS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [4:0]          paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                valid_i,
  output logic               stall_o,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic signed [31:0] origin_z_i,
  input  wire logic signed [31:0] dir_x_i,
  input  wire logic signed [31:0] dir_y_i,
  input  wire logic signed [31:0] dir_z_i,
  input  wire logic signed [31:0] enter_dist_i,
  input  wire logic signed [31:0] exit_dist_i,
  output logic               valid_o,
  input  wire                stall_i,
  output logic               hit_o,
  output logic signed [31:0] new_enter_o,
  output logic signed [31:0] new_exit_o,
  output logic [1:0]         enter_surface_o,
  output logic [1:0]         exit_surface_o
);

  localparam int TLAT = rppc_pkg::DIV_STEPS + 4;
  localparam int LAT  = TLAT + 2;

  logic signed [31:0] reg_q [rppc_pkg::NUM_REGS];
  logic [2:0]         ridx;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;
  assign prdata = reg_q[ridx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rppc_pkg::NUM_REGS; i++) begin
        reg_q[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      reg_q[ridx] <= pwdata;
    end
  end

  logic en;
  logic vld_q [LAT];

  assign en      = !vld_q[LAT-1] || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  logic signed [31:0] ent_q [TLAT];
  logic signed [31:0] ext_q [TLAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q[0] <= enter_dist_i;
      ext_q[0] <= exit_dist_i;
      for (int i = 1; i < TLAT; i++) begin
        ent_q[i] <= ent_q[i-1];
        ext_q[i] <= ext_q[i-1];
      end
    end
  end

  logic signed [31:0]     t_bot, t_top;
  rppc_pkg::plane_flags_t f_bot, f_top;

  rppc_plane #(.FRAC_BITS(FRAC_BITS)) u_bot (
    .clk_i      (clk_i),
    .en_i       (en),
    .plane_a_i  (reg_q[rppc_pkg::REG_BOTTOM_A]),
    .plane_b_i  (reg_q[rppc_pkg::REG_BOTTOM_B]),
    .plane_c_i  (reg_q[rppc_pkg::REG_BOTTOM_C]),
    .plane_d_i  (reg_q[rppc_pkg::REG_BOTTOM_D]),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .t_o        (t_bot),
    .flags_o    (f_bot)
  );

  rppc_plane #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk_i      (clk_i),
    .en_i       (en),
    .plane_a_i  (reg_q[rppc_pkg::REG_TOP_A]),
    .plane_b_i  (reg_q[rppc_pkg::REG_TOP_B]),
    .plane_c_i  (reg_q[rppc_pkg::REG_TOP_C]),
    .plane_d_i  (reg_q[rppc_pkg::REG_TOP_D]),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .t_o        (t_top),
    .flags_o    (f_top)
  );

  rppc_clip u_clip (
    .clk_i           (clk_i),
    .en_i            (en),
    .enter_i         (ent_q[TLAT-1]),
    .exit_i          (ext_q[TLAT-1]),
    .t_bot_i         (t_bot),
    .flags_bot_i     (f_bot),
    .t_top_i         (t_top),
    .flags_top_i     (f_top),
    .hit_o           (hit_o),
    .new_enter_o     (new_enter_o),
    .new_exit_o      (new_exit_o),
    .enter_surface_o (enter_surface_o),
    .exit_surface_o  (exit_surface_o)
  );

endmodule
`default_nettype wire
